@@ rtl/pccq_pkg.sv @@
// ----------------------------------------------------------------------------
// pccq_pkg
// Shared widths, defaults and codes for the connection quota block.
// ----------------------------------------------------------------------------
package pccq_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COUNT_WIDTH_DEF   = 16;

    localparam int KEY_W    = 64;
    localparam int CFG_W    = 16;
    localparam int OUT_W    = 16;
    localparam int LIMIT_W  = 16;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_ACQUIRE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIENT_CAP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_CAP  = 1'b1;

    // response status codes
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUOTA   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

endpackage

@@ rtl/pccq_ram.sv @@
// ----------------------------------------------------------------------------
// pccq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pccq_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/per_client_connection_quota.sv @@
// ----------------------------------------------------------------------------
// per_client_connection_quota
// Connection admission control with a per-client and a total open count.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_valid / o_ready): opcode, client key, key_valid flag,
//   use_default_limit and an override limit. Opcodes: acquire, release, query.
//   Response channel (o_valid / i_ready): status, the client's count and the
//   total count as they stand after the transaction.
//   Config port: i_cfg_wr_en with i_cfg_index (0 per-client cap, 1 total cap)
//   and i_cfg_wdata; written at once, accepted in every state.
// Timing:
//   Every transaction scans the whole client table through one RAM read port,
//   one entry per cycle, through a single 64-bit key comparator. The scan and
//   a decide step lie between accept and response valid, and the response is
//   registered; the next request is taken the cycle after the response is
//   taken, so no new request is taken while one is in flight.
// Reset:
//   The total clears; registers return to 8 and 1024. A clearing pass then
//   zeroes the table, one entry per cycle, with o_ready low. An entry is in
//   use exactly when its count is non-zero.
// Stall:
//   The response is held in an output register while i_ready is low; no new
//   request is taken until it is delivered.
// ----------------------------------------------------------------------------
module per_client_connection_quota #(
    parameter int TABLE_ENTRIES = pccq_pkg::TABLE_ENTRIES_DEF,
    parameter int COUNT_WIDTH   = pccq_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // config write port
    input  logic                            i_cfg_wr_en,
    input  logic [pccq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pccq_pkg::CFG_W-1:0]      i_cfg_wdata,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [pccq_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [pccq_pkg::KEY_W-1:0]      i_client_key,
    input  logic                            i_key_valid,
    input  logic                            i_use_default_limit,
    input  logic [pccq_pkg::LIMIT_W-1:0]    i_client_limit,
    // response channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pccq_pkg::STATUS_W-1:0]   o_status,
    output logic [pccq_pkg::OUT_W-1:0]      o_held_count,
    output logic [pccq_pkg::OUT_W-1:0]      o_total_count
);

    import pccq_pkg::*;

    localparam int AW    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = AW + 1;
    localparam int RAM_W = KEY_W + COUNT_WIDTH;
    // common width for count / limit compares
    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    localparam logic [CNT_W-1:0] SCAN_END   = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CLEAR_LAST = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [CFG_W-1:0] CLIENT_CAP_RST = 16'd8;
    localparam logic [CFG_W-1:0] TOTAL_CAP_RST  = 16'd1024;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_RESP
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CFG_W-1:0]       r_client_cap, n_client_cap;
    logic [CFG_W-1:0]       r_total_cap, n_total_cap;
    logic [COUNT_WIDTH-1:0] r_total, n_total;

    // latched request
    logic [OPCODE_W-1:0]    r_op, n_op;
    logic [KEY_W-1:0]       r_key, n_key;
    logic                   r_key_valid, n_key_valid;
    logic                   r_use_def, n_use_def;
    logic [LIMIT_W-1:0]     r_limit, n_limit;

    // scan results
    logic                   r_found, n_found;
    logic [AW-1:0]          r_found_idx, n_found_idx;
    logic [COUNT_WIDTH-1:0] r_found_count, n_found_count;
    logic                   r_free_found, n_free_found;
    logic [AW-1:0]          r_free_idx, n_free_idx;

    // response register
    logic                   r_o_valid, n_o_valid;
    logic [STATUS_W-1:0]    r_o_status, n_o_status;
    logic [OUT_W-1:0]       r_o_client, n_o_client;
    logic [OUT_W-1:0]       r_o_total, n_o_total;

    // table RAM: {key, count}
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [RAM_W-1:0]       ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [RAM_W-1:0]       ram_rdata;
    logic [KEY_W-1:0]       rd_key;
    logic [COUNT_WIDTH-1:0] rd_count;
    logic [AW-1:0]          chk_idx;

    // decision terms
    logic [LIMIT_W-1:0]     acq_limit;
    logic                   acq_invalid;
    logic                   acq_quota;

    pccq_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[RAM_W-1:COUNT_WIDTH];
    assign rd_count = ram_rdata[COUNT_WIDTH-1:0];
    // read data in this cycle belongs to the address issued last cycle
    assign chk_idx  = r_cnt[AW-1:0] - 1'b1;

    assign acq_limit   = r_use_def ? r_client_cap : r_limit;
    assign acq_invalid = !r_key_valid || (acq_limit == '0) ||
                         (acq_limit > r_client_cap);
    // saturating counts: a full-scale count also refuses
    assign acq_quota   = (CMP_W'(r_total) >= CMP_W'(r_total_cap)) ||
                         (CMP_W'(r_found_count) >= CMP_W'(acq_limit)) ||
                         (r_total == COUNT_MAX) || (r_found_count == COUNT_MAX);

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        n_client_cap     = r_client_cap;
        n_total_cap      = r_total_cap;
        n_total          = r_total;
        n_op             = r_op;
        n_key            = r_key;
        n_key_valid      = r_key_valid;
        n_use_def        = r_use_def;
        n_limit          = r_limit;
        n_found          = r_found;
        n_found_idx      = r_found_idx;
        n_found_count    = r_found_count;
        n_free_found     = r_free_found;
        n_free_idx       = r_free_idx;
        n_o_valid        = r_o_valid;
        n_o_status       = r_o_status;
        n_o_client       = r_o_client;
        n_o_total        = r_o_total;
        ram_we           = 1'b0;
        ram_waddr        = r_cnt[AW-1:0];
        ram_wdata        = '0;
        ram_raddr        = r_cnt[AW-1:0];

        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_CLIENT_CAP: n_client_cap = i_cfg_wdata;
                REG_TOTAL_CAP:  n_total_cap  = i_cfg_wdata;
                default:        n_total_cap  = r_total_cap;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CLEAR_LAST) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_valid) begin
                    n_op          = i_opcode;
                    n_key         = i_client_key;
                    n_key_valid   = i_key_valid;
                    n_use_def     = i_use_default_limit;
                    n_limit       = i_client_limit;
                    n_cnt         = '0;
                    n_found       = 1'b0;
                    n_found_count = '0;
                    n_free_found  = 1'b0;
                    n_state       = S_SCAN;
                end
            end

            S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    if ((rd_count != '0) && (rd_key == r_key)) begin
                        n_found       = 1'b1;
                        n_found_idx   = chk_idx;
                        n_found_count = rd_count;
                    end
                    // lowest free entry
                    if ((rd_count == '0) && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = chk_idx;
                    end
                end
                if (r_cnt == SCAN_END) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                n_o_valid  = 1'b1;
                n_o_status = ST_DONE;
                n_o_client = OUT_W'(r_found_count);
                n_state    = S_RESP;
                case (r_op)
                    OP_ACQUIRE: begin
                        if (acq_invalid) begin
                            n_o_status = ST_INVALID;
                        end else if (acq_quota) begin
                            n_o_status = ST_QUOTA;
                        end else if (!r_found && !r_free_found) begin
                            n_o_status = ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = r_found ? r_found_idx : r_free_idx;
                            ram_wdata  = {r_key, r_found_count + 1'b1};
                            n_total    = r_total + 1'b1;
                            n_o_client = OUT_W'(r_found_count + 1'b1);
                        end
                    end
                    OP_RELEASE: begin
                        if (!r_found || (r_found_count == '0) || (r_total == '0)) begin
                            n_o_status = ST_IGNORED;
                        end else begin
                            // count of zero frees the entry
                            ram_we     = 1'b1;
                            ram_waddr  = r_found_idx;
                            ram_wdata  = {r_key, r_found_count - 1'b1};
                            n_total    = r_total - 1'b1;
                            n_o_client = OUT_W'(r_found_count - 1'b1);
                        end
                    end
                    OP_QUERY: begin
                        n_o_status = ST_DONE;
                    end
                    default: begin
                        n_o_status = ST_INVALID;
                    end
                endcase
                n_o_total = OUT_W'(n_total);
            end

            S_RESP: begin
                if (i_ready) begin
                    n_o_valid = 1'b0;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_CLEAR;
            r_cnt            <= '0;
            r_client_cap     <= CLIENT_CAP_RST;
            r_total_cap      <= TOTAL_CAP_RST;
            r_total          <= '0;
            r_o_valid        <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_cnt            <= n_cnt;
            r_client_cap     <= n_client_cap;
            r_total_cap      <= n_total_cap;
            r_total          <= n_total;
            r_op             <= n_op;
            r_key            <= n_key;
            r_key_valid      <= n_key_valid;
            r_use_def        <= n_use_def;
            r_limit          <= n_limit;
            r_found          <= n_found;
            r_found_idx      <= n_found_idx;
            r_found_count    <= n_found_count;
            r_free_found     <= n_free_found;
            r_free_idx       <= n_free_idx;
            r_o_valid        <= n_o_valid;
            r_o_status       <= n_o_status;
            r_o_client       <= n_o_client;
            r_o_total        <= n_o_total;
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_held_count   = r_o_client;
    assign o_total_count  = r_o_total;

endmodule

@@ rtl/pccq_checker.sv @@
// ----------------------------------------------------------------------------
// pccq_checker
// Port-level checks for the connection quota block, bound to the top level.
// ----------------------------------------------------------------------------
module pccq_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [pccq_pkg::STATUS_W-1:0] o_status,
    input  logic [pccq_pkg::OUT_W-1:0]    o_held_count,
    input  logic [pccq_pkg::OUT_W-1:0]    o_total_count
);

    import pccq_pkg::*;

    // no response survives reset
    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid after reset");

    // one transaction in flight: accept drops ready
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready held after accept");

    a_no_ready_with_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("ready while response pending");

    // table full only for a client with no entry
    a_full_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL)) |-> (o_held_count == '0))
        else $error("table full with non-zero client count");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_status) && $stable(o_held_count) &&
             $stable(o_total_count)))
        else $error("stalled response changed");

endmodule

bind per_client_connection_quota pccq_checker u_pccq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_held_count   (o_held_count),
    .o_total_count  (o_total_count)
);

@@ dv/per_client_connection_quota_test.sv @@
// ----------------------------------------------------------------------------
// per_client_connection_quota_test
// Self-checking bench for the connection quota block. A scoreboard keeps its
// own copy of the client table, the total and both limit registers, predicts
// the response of every accepted request and compares each delivered response
// field by field. Directed requests cover the field extremes and every rule;
// random phases then sweep several limit settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module per_client_connection_quota_test;

    localparam int SLOTS     = pccq_pkg::TABLE_ENTRIES_DEF;
    localparam int COUNT_TOP = (1 << pccq_pkg::COUNT_WIDTH_DEF) - 1;
    localparam int POOL_MAX  = 96;

    typedef enum logic [pccq_pkg::OPCODE_W-1:0] {
        OP_ACQUIRE = pccq_pkg::OP_ACQUIRE,
        OP_RELEASE = pccq_pkg::OP_RELEASE,
        OP_QUERY   = pccq_pkg::OP_QUERY
    } t_quota_op;

    typedef struct packed {
        logic [pccq_pkg::STATUS_W-1:0] status;
        logic [pccq_pkg::OUT_W-1:0]    held_count;
        logic [pccq_pkg::OUT_W-1:0]    total_count;
    } t_quota_reply;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the client table and predicts one reply per request
    // ------------------------------------------------------------------------
    class quota_scoreboard;
        logic [pccq_pkg::KEY_W-1:0] slot_key [SLOTS];
        int                         slot_count [SLOTS];
        bit                         slot_used [SLOTS];
        int                         open_total;
        int                         cap_client;
        int                         cap_total;
        t_quota_reply               waiting [$];
        int                         mismatches;
        int                         checked;
        int                         status_seen [8];

        function new();
            foreach (slot_used[i]) begin
                slot_used[i]  = 1'b0;
                slot_count[i] = 0;
                slot_key[i]   = '0;
            end
            foreach (status_seen[i]) status_seen[i] = 0;
            open_total = 0;
            cap_client = 8;
            cap_total  = 1024;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void set_limits(int per_client, int total);
            cap_client = per_client;
            cap_total  = total;
        endfunction

        function int pending();
            return waiting.size();
        endfunction

        // keys only match in slots that are in use
        function int find_client(logic [pccq_pkg::KEY_W-1:0] key);
            for (int i = 0; i < SLOTS; i++)
                if (slot_used[i] && slot_key[i] == key) return i;
            return -1;
        endfunction

        function int lowest_free();
            for (int i = 0; i < SLOTS; i++)
                if (!slot_used[i]) return i;
            return -1;
        endfunction

        function logic [pccq_pkg::STATUS_W-1:0] acquire(
            logic [pccq_pkg::KEY_W-1:0] key, logic key_ok, logic use_def,
            logic [pccq_pkg::LIMIT_W-1:0] limit);
            int lim;
            int slot;
            int held;
            if (!key_ok) return pccq_pkg::ST_INVALID;
            lim = use_def ? cap_client : int'(limit);
            if (lim == 0 || lim > cap_client) return pccq_pkg::ST_INVALID;
            slot = find_client(key);
            held = (slot >= 0) ? slot_count[slot] : 0;
            // counts saturate rather than wrap
            if (open_total >= cap_total || held >= lim ||
                open_total >= COUNT_TOP || held >= COUNT_TOP)
                return pccq_pkg::ST_QUOTA;
            if (slot < 0) begin
                slot = lowest_free();
                if (slot < 0) return pccq_pkg::ST_FULL;
                slot_used[slot]  = 1'b1;
                slot_key[slot]   = key;
                slot_count[slot] = 0;
            end
            slot_count[slot]++;
            open_total++;
            return pccq_pkg::ST_DONE;
        endfunction

        function logic [pccq_pkg::STATUS_W-1:0] retire(logic [pccq_pkg::KEY_W-1:0] key);
            int slot;
            slot = find_client(key);
            if (slot < 0 || slot_count[slot] == 0 || open_total == 0)
                return pccq_pkg::ST_IGNORED;
            open_total--;
            slot_count[slot]--;
            if (slot_count[slot] == 0) slot_used[slot] = 1'b0;
            return pccq_pkg::ST_DONE;
        endfunction

        function void note_request(t_quota_op op, logic [pccq_pkg::KEY_W-1:0] key,
                                   logic key_ok, logic use_def,
                                   logic [pccq_pkg::LIMIT_W-1:0] limit);
            t_quota_reply r;
            int           slot;
            case (op)
                OP_ACQUIRE: r.status = acquire(key, key_ok, use_def, limit);
                OP_RELEASE: r.status = retire(key);
                OP_QUERY:   r.status = pccq_pkg::ST_DONE;
                default:    r.status = pccq_pkg::ST_INVALID;
            endcase
            // client count is reported whatever the status
            slot = find_client(key);
            r.held_count  = (slot >= 0) ? pccq_pkg::OUT_W'(slot_count[slot]) : '0;
            r.total_count = pccq_pkg::OUT_W'(open_total);
            waiting.push_back(r);
        endfunction

        function void check_response(logic [pccq_pkg::STATUS_W-1:0] status,
                                     logic [pccq_pkg::OUT_W-1:0] held_count,
                                     logic [pccq_pkg::OUT_W-1:0] total_count);
            t_quota_reply want;
            if (waiting.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: response with nothing outstanding: ",
                              "status %0d client %0d total %0d"},
                             status, held_count, total_count);
                return;
            end
            want = waiting.pop_front();
            checked++;
            status_seen[want.status]++;
            if (status !== want.status || held_count !== want.held_count ||
                total_count !== want.total_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: response %0d: status %0d/%0d client %0d/%0d ",
                              "total %0d/%0d (exp/act)"},
                             checked, want.status, status, want.held_count, held_count,
                             want.total_count, total_count);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals. Every bench-driven signal starts at a known value.
    // ------------------------------------------------------------------------
    logic                            i_clk               = 1'b0;
    logic                            i_rst_n             = 1'b0;
    logic                            i_cfg_wr_en         = 1'b0;
    logic [pccq_pkg::CFG_IDX_W-1:0]  i_cfg_index         = '0;
    logic [pccq_pkg::CFG_W-1:0]      i_cfg_wdata         = '0;
    logic                            i_valid             = 1'b0;
    logic                            o_ready;
    logic [pccq_pkg::OPCODE_W-1:0]   i_opcode            = '0;
    logic [pccq_pkg::KEY_W-1:0]      i_client_key        = '0;
    logic                            i_key_valid         = 1'b0;
    logic                            i_use_default_limit = 1'b0;
    logic [pccq_pkg::LIMIT_W-1:0]    i_client_limit      = '0;
    logic                            o_valid;
    logic                            i_ready             = 1'b0;
    logic [pccq_pkg::STATUS_W-1:0]   o_status;
    logic [pccq_pkg::OUT_W-1:0]      o_held_count;
    logic [pccq_pkg::OUT_W-1:0]      o_total_count;

    always #10 i_clk = ~i_clk;

    per_client_connection_quota dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_opcode            (i_opcode),
        .i_client_key        (i_client_key),
        .i_key_valid         (i_key_valid),
        .i_use_default_limit (i_use_default_limit),
        .i_client_limit      (i_client_limit),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_status            (o_status),
        .o_held_count        (o_held_count),
        .o_total_count       (o_total_count)
    );

    quota_scoreboard            ledger;
    int                         sender_idle_pct = 0;   // chance per cycle the sender holds off
    int                         recv_stall_pct  = 0;   // chance per cycle i_ready is low
    int                         settings_used   = 1;   // reset values count as one setting
    logic [pccq_pkg::KEY_W-1:0] pool_keys [POOL_MAX];

    // ------------------------------------------------------------------------
    // Response side: random backpressure, and every delivered transaction
    // goes to the scoreboard. Values are sampled as they stood at the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk)
        i_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready)
            ledger.check_response(o_status, o_held_count, o_total_count);

    // ------------------------------------------------------------------------
    // Request side. Called at a rising edge. i_valid stays high between
    // back-to-back transactions; it only drops for an idle gap or at the end
    // of a phase, so it never gets two assignments in one step.
    // ------------------------------------------------------------------------
    task automatic send_request(input t_quota_op op, input logic [pccq_pkg::KEY_W-1:0] key,
                                input logic key_ok, input logic use_def,
                                input logic [pccq_pkg::LIMIT_W-1:0] limit);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_valid             <= 1'b1;
        i_opcode            <= op;
        i_client_key        <= key;
        i_key_valid         <= key_ok;
        i_use_default_limit <= use_def;
        i_client_limit      <= limit;
        do @(posedge i_clk); while (!o_ready);
        ledger.note_request(op, key, key_ok, use_def, limit);
    endtask

    // Wait until every predicted response has been delivered.
    task automatic drain();
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    // Both registers, back to back; only called with nothing in flight.
    task automatic write_limits(input int per_client, input int total);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= pccq_pkg::REG_CLIENT_CAP;
        i_cfg_wdata <= pccq_pkg::CFG_W'(per_client);
        @(posedge i_clk);
        i_cfg_index <= pccq_pkg::REG_TOTAL_CAP;
        i_cfg_wdata <= pccq_pkg::CFG_W'(total);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        ledger.set_limits(per_client, total);
        settings_used++;
    endtask

    // Mostly keys from a shared pool so clients come back and fill up; a few
    // fresh keys act as strangers (unknown releases, new table entries).
    task automatic random_request(input int pool_n, input int acquire_pct);
        t_quota_op                    op;
        logic [pccq_pkg::KEY_W-1:0]   key;
        logic                         key_ok;
        logic                         use_def;
        logic [pccq_pkg::LIMIT_W-1:0] limit;
        int                           roll;
        int                           cap;
        roll = $urandom_range(99);
        if (roll < acquire_pct)
            op = OP_ACQUIRE;
        else if (roll < acquire_pct + (100 - acquire_pct) * 2 / 3)
            op = OP_RELEASE;
        else
            op = OP_QUERY;
        if ($urandom_range(99) < 8)
            key = {$urandom, $urandom};
        else
            key = pool_keys[$urandom_range(pool_n - 1)];
        key_ok  = ($urandom_range(99) >= 8);
        use_def = 1'($urandom_range(1));
        cap     = ledger.cap_client;
        // override limit: mostly legal, some zero, some just over the ceiling
        case ($urandom_range(9))
            0:       limit = '0;
            1:       limit = pccq_pkg::LIMIT_W'($urandom);
            2:       limit = (cap < COUNT_TOP) ? pccq_pkg::LIMIT_W'(cap + 1) : '1;
            default: limit = pccq_pkg::LIMIT_W'($urandom_range(cap, 1));
        endcase
        send_request(op, key, key_ok, use_def, limit);
    endtask

    task automatic run_phase(input int items, input int per_client, input int total,
                             input int pool_n, input int acquire_pct,
                             input int idle_pct, input int stall_pct);
        drain();
        write_limits(per_client, total);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (items) random_request(pool_n, acquire_pct);
        i_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [pccq_pkg::KEY_W-1:0] key_a;
        logic [pccq_pkg::KEY_W-1:0] key_b;
        int                         grants;

        ledger = new();
        key_a  = 64'h0123_4567_89AB_CDEF;
        key_b  = 64'hFEDC_BA98_7654_3210;

        // key pool: the two extreme keys, a few keys one bit apart, the rest random
        foreach (pool_keys[i]) pool_keys[i] = {$urandom, $urandom};
        pool_keys[0] = '0;
        pool_keys[1] = '1;
        pool_keys[2] = pool_keys[6] ^ 64'h0000_0000_0000_0001;
        pool_keys[3] = pool_keys[6] ^ 64'h0000_0000_8000_0000;
        pool_keys[4] = pool_keys[6] ^ 64'h0000_0001_0000_0000;
        pool_keys[5] = pool_keys[6] ^ 64'h8000_0000_0000_0000;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, at the reset limits (8 per client, 1024 total) ---
        send_request(OP_QUERY,   key_a, 1'b1, 1'b0, 16'd0);     // unknown client
        send_request(OP_ACQUIRE, key_a, 1'b0, 1'b1, 16'd0);     // key failed validation
        send_request(OP_ACQUIRE, key_a, 1'b1, 1'b1, 16'd0);     // default limit
        send_request(OP_ACQUIRE, key_a, 1'b1, 1'b0, 16'd0);     // zero limit
        send_request(OP_ACQUIRE, key_a, 1'b1, 1'b0, 16'd9);     // one over ceiling
        send_request(OP_ACQUIRE, key_a, 1'b1, 1'b0, 16'hFFFF);  // far over ceiling
        send_request(OP_ACQUIRE, key_a, 1'b1, 1'b0, 16'd1);     // already at its limit
        send_request(OP_ACQUIRE, key_a, 1'b1, 1'b0, 16'd8);
        send_request(OP_RELEASE, key_b, 1'b1, 1'b0, 16'd0);     // unknown client
        send_request(OP_RELEASE, key_a, 1'b0, 1'b0, 16'd0);     // key_valid ignored here
        send_request(OP_RELEASE, key_a, 1'b1, 1'b0, 16'd0);     // count hits zero, slot freed
        send_request(OP_RELEASE, key_a, 1'b1, 1'b0, 16'd0);     // nothing left to release
        send_request(OP_ACQUIRE, '1,    1'b1, 1'b1, 16'hFFFF);  // default wins over override
        // zero key up to its per-client limit, then one refused
        for (grants = 0; grants < 9; grants++)
            send_request(OP_ACQUIRE, '0, 1'b1, 1'b0, 16'd8);
        send_request(OP_QUERY,   '1,    1'b0, 1'b1, 16'hFFFF);
        i_valid <= 1'b0;

        // --- random phases: limit settings and idle patterns ---
        // items, per client, total, pool, acquire %, sender idle %, stall %
        run_phase(200,     8,  1024,  8, 50,  0,  0);
        run_phase(250,     2, 65535, 90, 70, 55,  0);   // many clients: table fills
        run_phase(250, 65535,     0, 12, 50,  0, 55);   // total cap below what is held
        run_phase(250,     3,    20, 10, 55, 16, 16);   // total cap reached often
        run_phase(250,     1, 65535, 70, 45,  0,  0);
        run_phase(250,   100,   300,  6, 60, 55,  0);   // deep per-client counts

        drain();
        repeat (2 * SLOTS + 8) @(posedge i_clk);

        $display("run covered %0d checked transactions under %0d limit settings",
                 ledger.checked, settings_used);
        $display({"statuses seen: done %0d, invalid %0d, quota %0d, ",
                  "table full %0d, ignored %0d"},
                 ledger.status_seen[pccq_pkg::ST_DONE],
                 ledger.status_seen[pccq_pkg::ST_INVALID],
                 ledger.status_seen[pccq_pkg::ST_QUOTA],
                 ledger.status_seen[pccq_pkg::ST_FULL],
                 ledger.status_seen[pccq_pkg::ST_IGNORED]);
        if (ledger.mismatches == 0 && ledger.pending() == 0)
            $display("per_client_connection_quota_test: done, clean");
        else
            $display("per_client_connection_quota_test: done, errors");
        $finish;
    end

    // Hard stop, far beyond the slowest expected run.
    initial begin
        #(64'd20 * 64'd1_000_000);
        $display("TIMEOUT: %0d responses still outstanding", ledger.pending());
        $display("per_client_connection_quota_test: done, errors");
        $finish;
    end

endmodule
